// ----- src/mandel_pkg.sv -----
// shared types, constants and helpers for the escape-time pixel block
// used by mandel_mul, mandel_div and mandelbrot_escape_time_pixel
// no dependencies
package mandel_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = 12;
  localparam int COUNT_W   = 16;
  localparam int FRAC_BITS = 28;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int DIV_W     = 44;
  localparam int DIV_CNT_W = 6;
  localparam int SAT_W     = 48;

  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);
  localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(1);

  // 4.0 in Q8.56
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic signed [SAT_W-1:0] COORD_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] COORD_MIN = SAT_W'(-64'sd2147483648);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_MUL_RR,
    ST_MUL_II,
    ST_CHECK,
    ST_MUL_RI,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic [DIV_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             ready;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/mandel_mul.sv -----
// shared signed 32 x 32 multiplier with registered 64-bit product
// depends on mandel_pkg
module mandel_mul (
  input  logic                                    clk,
  input  logic signed [mandel_pkg::COORD_W-1:0]   a,
  input  logic signed [mandel_pkg::COORD_W-1:0]   b,
  output logic signed [mandel_pkg::PROD_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- src/mandel_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on mandel_pkg
module mandel_div (
  input  logic                  clk,
  input  logic                  rst,
  input  mandel_pkg::div_req_t  req,
  output mandel_pkg::div_rsp_t  rsp
);

  logic [mandel_pkg::DIV_W-1:0]     quo;
  logic [mandel_pkg::DIM_W-1:0]     rem;
  logic [mandel_pkg::DIM_W-1:0]     dvs;
  logic [mandel_pkg::DIV_CNT_W-1:0] cnt;
  logic [mandel_pkg::DIM_W:0]       trial;
  logic                             ge;

  // remainder stays below the divisor, so 13 bits plus the incoming bit suffice
  always_comb begin
    trial = {rem, quo[mandel_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.load) begin
      cnt <= mandel_pkg::DIV_CNT_W'(mandel_pkg::DIV_W);
    end else if (cnt != '0) begin
      cnt <= cnt - mandel_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (cnt != '0) begin
      quo <= {quo[mandel_pkg::DIV_W-2:0], ge};
      rem <= ge ? mandel_pkg::DIM_W'(trial - {1'b0, dvs}) : trial[mandel_pkg::DIM_W-1:0];
    end
  end

  assign rsp.ready    = (cnt == '0);
  assign rsp.quotient = quo;

endmodule

// ----- src/mandelbrot_escape_time_pixel.sv -----
// escape-time evaluation of one pixel: map to c, iterate z = z*z + c
// the next start is taken the cycle after done. mapping uses the 44-step divider
// twice, each iteration steps through MUL_RR, MUL_II, CHECK, MUL_RI and UPDATE on
// the one shared 32 x 32 multiplier.
// done is a single-cycle strobe the receiver cannot stall.
// reset (rst, synchronous) returns the sequencer to idle and the config registers to defaults
module mandelbrot_escape_time_pixel (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_write,
  input  logic [mandel_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mandel_pkg::CFG_W-1:0]               cfg_data,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [mandel_pkg::IDX_W-1:0]               column_index,
  input  logic [mandel_pkg::IDX_W-1:0]               row_index,
  output logic                                       done,
  output logic signed [mandel_pkg::COORD_W-1:0]      point_real,
  output logic signed [mandel_pkg::COORD_W-1:0]      point_imag,
  output logic [mandel_pkg::COUNT_W-1:0]             iteration_count,
  output logic signed [mandel_pkg::COORD_W-1:0]      final_real,
  output logic signed [mandel_pkg::COORD_W-1:0]      final_imag,
  output logic                                       inside_set
);

  // configuration
  logic signed [mandel_pkg::CFG_W-1:0] real_min;
  logic signed [mandel_pkg::CFG_W-1:0] real_max;
  logic signed [mandel_pkg::CFG_W-1:0] imag_min;
  logic signed [mandel_pkg::CFG_W-1:0] imag_max;
  logic [mandel_pkg::DIM_W-1:0]        columns_in_use;
  logic [mandel_pkg::DIM_W-1:0]        rows_in_use;
  logic [mandel_pkg::COUNT_W-1:0]      iteration_limit;

  mandel_pkg::state_t state;
  mandel_pkg::state_t state_next;
  logic               axis;

  // datapath registers
  logic [mandel_pkg::IDX_W-1:0]          col_q;
  logic [mandel_pkg::IDX_W-1:0]          row_q;
  logic                                  quo_neg;
  logic signed [mandel_pkg::COORD_W-1:0] cr;
  logic signed [mandel_pkg::COORD_W-1:0] ci;
  logic signed [mandel_pkg::COORD_W-1:0] zr;
  logic signed [mandel_pkg::COORD_W-1:0] zi;
  logic signed [mandel_pkg::COORD_W-1:0] nr;
  logic signed [mandel_pkg::PROD_W-1:0]  rr;
  logic signed [mandel_pkg::PROD_W-1:0]  ii;
  logic [mandel_pkg::COUNT_W-1:0]        n;
  logic                                  bounded;

  logic signed [mandel_pkg::COORD_W-1:0] mul_a;
  logic signed [mandel_pkg::COORD_W-1:0] mul_b;
  logic signed [mandel_pkg::PROD_W-1:0]  prod;
  mandel_pkg::div_req_t                  div_req;
  mandel_pkg::div_rsp_t                  div_rsp;

  logic signed [mandel_pkg::COORD_W-1:0] diff_re;
  logic signed [mandel_pkg::COORD_W-1:0] diff_im;
  logic [mandel_pkg::DIM_W-1:0]          dim_raw;
  logic [mandel_pkg::DIM_W-1:0]          dim_eff;
  logic [mandel_pkg::PROD_W-1:0]         prod_mag;
  logic signed [mandel_pkg::DIV_W:0]     quo_signed;
  logic signed [mandel_pkg::CFG_W-1:0]   lo_sel;
  logic signed [mandel_pkg::COORD_W-1:0] mapped;
  logic [mandel_pkg::PROD_W-1:0]         modulus;
  logic                                  keep_going;
  logic signed [mandel_pkg::PROD_W-1:0]  sq_diff;
  logic signed [mandel_pkg::COORD_W-1:0] nr_val;
  logic signed [mandel_pkg::COORD_W-1:0] ni_val;

  mandel_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  mandel_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // mapping arithmetic
  always_comb begin
    diff_re    = mandel_pkg::COORD_W'(real_max) - mandel_pkg::COORD_W'(real_min);
    diff_im    = mandel_pkg::COORD_W'(imag_max) - mandel_pkg::COORD_W'(imag_min);
    dim_raw    = axis ? rows_in_use : columns_in_use;
    if (dim_raw == '0) begin
      dim_eff = mandel_pkg::MIN_DIM;
    end else if (dim_raw > mandel_pkg::MAX_DIM) begin
      dim_eff = mandel_pkg::MAX_DIM;
    end else begin
      dim_eff = dim_raw;
    end
    prod_mag   = prod[mandel_pkg::PROD_W-1] ? mandel_pkg::PROD_W'(-prod)
                                            : mandel_pkg::PROD_W'(prod);
    // truncating division: divide the magnitude, then restore the sign
    quo_signed = quo_neg ? -$signed({1'b0, div_rsp.quotient})
                         : $signed({1'b0, div_rsp.quotient});
    lo_sel     = axis ? imag_min : real_min;
    mapped     = mandel_pkg::sat_coord(mandel_pkg::SAT_W'(lo_sel)
                                       + mandel_pkg::SAT_W'(quo_signed));
  end

  // iteration arithmetic
  always_comb begin
    modulus    = $unsigned(rr) + $unsigned(prod);
    keep_going = (modulus < mandel_pkg::ESCAPE_LIMIT) && (n < iteration_limit);
    sq_diff    = rr - ii;
    nr_val     = mandel_pkg::sat_coord(
                   mandel_pkg::SAT_W'($signed(sq_diff[mandel_pkg::PROD_W-1:mandel_pkg::FRAC_BITS]))
                   + mandel_pkg::SAT_W'(cr));
    ni_val     = mandel_pkg::sat_coord(
                   mandel_pkg::SAT_W'($signed(prod[mandel_pkg::PROD_W-1:mandel_pkg::FRAC_BITS-1]))
                   + mandel_pkg::SAT_W'(ci));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mandel_pkg::ST_IDLE:     if (start) state_next = mandel_pkg::ST_MAP_MUL;
      mandel_pkg::ST_MAP_MUL:  state_next = mandel_pkg::ST_MAP_DIV;
      mandel_pkg::ST_MAP_DIV:  state_next = mandel_pkg::ST_MAP_WAIT;
      mandel_pkg::ST_MAP_WAIT: begin
        if (div_rsp.ready) begin
          state_next = axis ? mandel_pkg::ST_MUL_RR : mandel_pkg::ST_MAP_MUL;
        end
      end
      mandel_pkg::ST_MUL_RR:   state_next = mandel_pkg::ST_MUL_II;
      mandel_pkg::ST_MUL_II:   state_next = mandel_pkg::ST_CHECK;
      mandel_pkg::ST_CHECK: begin
        state_next = keep_going ? mandel_pkg::ST_MUL_RI : mandel_pkg::ST_DONE;
      end
      mandel_pkg::ST_MUL_RI:   state_next = mandel_pkg::ST_UPDATE;
      mandel_pkg::ST_UPDATE:   state_next = mandel_pkg::ST_MUL_RR;
      mandel_pkg::ST_DONE:     state_next = mandel_pkg::ST_IDLE;
      default:                 state_next = mandel_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_a            = zr;
    mul_b            = zr;
    div_req.load     = 1'b0;
    div_req.dividend = prod_mag[mandel_pkg::DIV_W-1:0];
    div_req.divisor  = dim_eff;
    done             = 1'b0;
    busy             = (state != mandel_pkg::ST_IDLE);
    unique case (state)
      mandel_pkg::ST_MAP_MUL: begin
        mul_a = axis ? diff_im : diff_re;
        mul_b = $signed(mandel_pkg::COORD_W'(axis ? row_q : col_q));
      end
      mandel_pkg::ST_MAP_DIV: div_req.load = 1'b1;
      mandel_pkg::ST_MUL_II: begin
        mul_a = zi;
        mul_b = zi;
      end
      mandel_pkg::ST_MUL_RI: mul_b = zi;
      mandel_pkg::ST_DONE:   done = 1'b1;
      default: ;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mandel_pkg::ST_IDLE;
      axis            <= 1'b0;
      real_min        <= '0;
      real_max        <= '0;
      imag_min        <= '0;
      imag_max        <= '0;
      columns_in_use  <= mandel_pkg::DIM_W'(1);
      rows_in_use     <= mandel_pkg::DIM_W'(1);
      iteration_limit <= '0;
    end else begin
      state <= state_next;
      if (state == mandel_pkg::ST_IDLE) begin
        axis <= 1'b0;
      end else if (state == mandel_pkg::ST_MAP_WAIT && div_rsp.ready) begin
        axis <= 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          mandel_pkg::REG_REAL_MIN:   real_min        <= cfg_data;
          mandel_pkg::REG_REAL_MAX:   real_max        <= cfg_data;
          mandel_pkg::REG_IMAG_MIN:   imag_min        <= cfg_data;
          mandel_pkg::REG_IMAG_MAX:   imag_max        <= cfg_data;
          mandel_pkg::REG_COLUMNS:    columns_in_use  <= cfg_data[mandel_pkg::DIM_W-1:0];
          mandel_pkg::REG_ROWS:       rows_in_use     <= cfg_data[mandel_pkg::DIM_W-1:0];
          mandel_pkg::REG_ITER_LIMIT: iteration_limit <= cfg_data[mandel_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      mandel_pkg::ST_IDLE: begin
        if (start) begin
          col_q <= column_index;
          row_q <= row_index;
          zr    <= '0;
          zi    <= '0;
          n     <= '0;
        end
      end
      mandel_pkg::ST_MAP_DIV: quo_neg <= prod[mandel_pkg::PROD_W-1];
      mandel_pkg::ST_MAP_WAIT: begin
        if (div_rsp.ready) begin
          if (axis) begin
            ci <= mapped;
          end else begin
            cr <= mapped;
          end
        end
      end
      mandel_pkg::ST_MUL_II: rr <= prod;
      mandel_pkg::ST_CHECK: begin
        ii      <= prod;
        bounded <= (modulus < mandel_pkg::ESCAPE_LIMIT);
      end
      mandel_pkg::ST_MUL_RI: nr <= nr_val;
      mandel_pkg::ST_UPDATE: begin
        zr <= nr;
        zi <= ni_val;
        n  <= n + mandel_pkg::COUNT_W'(1);
      end
      default: ;
    endcase
  end

  assign point_real      = cr;
  assign point_imag      = ci;
  assign iteration_count = n;
  assign final_real      = zr;
  assign final_imag      = zi;
  assign inside_set      = bounded;

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat outside a busy period");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat repeated");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
      done |-> (iteration_count <= iteration_limit))
    else $error("iteration count beyond limit");

  a_escape_needs_iter: assert property (@(posedge clk) disable iff (rst)
      (done && !inside_set) |-> (iteration_count != '0))
    else $error("escape reported with no iteration");

  a_start_takes: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted start did not raise busy");

endmodule

// ----- sim/tb_mandelbrot_escape_time_pixel.sv -----
// self-checking testbench for mandelbrot_escape_time_pixel: pixels are sent on the start/busy
// beat, each done beat is compared with an escape-time predictor kept in step with the registers
// depends on mandel_pkg and the block itself
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam longint      Q_ONE       = 64'sd268435456;   // 1.0 in Q4.28
  localparam longint      COORD_TOP   = 64'sd2147483647;
  localparam longint      COORD_BOTTOM = -64'sd2147483648;
  localparam longint unsigned ESCAPE_Q856 = 64'd4 << 56;
  localparam logic [mandel_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [mandel_pkg::COORD_W-1:0] c_re;
    logic signed [mandel_pkg::COORD_W-1:0] c_im;
    logic [mandel_pkg::COUNT_W-1:0]        count;
    logic signed [mandel_pkg::COORD_W-1:0] z_re;
    logic signed [mandel_pkg::COORD_W-1:0] z_im;
    logic                                  bounded;
  } pixel_result_t;

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_write;
  logic [mandel_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [mandel_pkg::CFG_W-1:0]           cfg_data;
  logic                                   start;
  logic                                   busy;
  logic [mandel_pkg::IDX_W-1:0]           column_index;
  logic [mandel_pkg::IDX_W-1:0]           row_index;
  logic                                   done;
  logic signed [mandel_pkg::COORD_W-1:0]  point_real;
  logic signed [mandel_pkg::COORD_W-1:0]  point_imag;
  logic [mandel_pkg::COUNT_W-1:0]         iteration_count;
  logic signed [mandel_pkg::COORD_W-1:0]  final_real;
  logic signed [mandel_pkg::COORD_W-1:0]  final_imag;
  logic                                   inside_set;

  // predictor copy of the register file
  logic signed [mandel_pkg::CFG_W-1:0] view_re_lo = '0;
  logic signed [mandel_pkg::CFG_W-1:0] view_re_hi = '0;
  logic signed [mandel_pkg::CFG_W-1:0] view_im_lo = '0;
  logic signed [mandel_pkg::CFG_W-1:0] view_im_hi = '0;
  logic [mandel_pkg::DIM_W-1:0]        zone_cols  = mandel_pkg::DIM_W'(1);
  logic [mandel_pkg::DIM_W-1:0]        zone_rows  = mandel_pkg::DIM_W'(1);
  logic [mandel_pkg::COUNT_W-1:0]      orbit_limit = '0;

  pixel_result_t pending_pixels[$];
  int unsigned   mismatches    = 0;
  int unsigned   results_seen  = 0;
  int unsigned   bounded_seen  = 0;
  int unsigned   longest_orbit = 0;
  int unsigned   views_tried   = 0;
  int unsigned   cycle_count   = 0;
  bit            tight_pacing  = 1'b0;

  mandelbrot_escape_time_pixel u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .column_index    (column_index),
    .row_index       (row_index),
    .done            (done),
    .point_real      (point_real),
    .point_imag      (point_imag),
    .iteration_count (iteration_count),
    .final_real      (final_real),
    .final_imag      (final_imag),
    .inside_set      (inside_set)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pending_pixels.size());
      $display("tb_mandelbrot_escape_time_pixel: errors");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_TOP) begin
      return COORD_TOP;
    end
    if (v < COORD_BOTTOM) begin
      return COORD_BOTTOM;
    end
    return v;
  endfunction

  // pixel index to plane coordinate, divisor held to 1..4096
  function automatic longint map_axis(logic signed [mandel_pkg::CFG_W-1:0] lo,
                                      logic signed [mandel_pkg::CFG_W-1:0] hi,
                                      logic [mandel_pkg::IDX_W-1:0] idx,
                                      logic [mandel_pkg::DIM_W-1:0] span);
    longint divisor;
    divisor = longint'(span);
    if (span == 0) begin
      divisor = 1;
    end else if (span > 4096) begin
      divisor = 4096;
    end
    return clamp_coord(longint'(lo) + (longint'(hi) - longint'(lo)) * longint'(idx) / divisor);
  endfunction

  function automatic pixel_result_t escape_time(logic [mandel_pkg::IDX_W-1:0] col,
                                                logic [mandel_pkg::IDX_W-1:0] row);
    pixel_result_t      r;
    longint             cr, ci, zr, zi, rr, ii, ri;
    longint unsigned    modulus;
    int unsigned        steps;
    cr = map_axis(view_re_lo, view_re_hi, col, zone_cols);
    ci = map_axis(view_im_lo, view_im_hi, row, zone_rows);
    zr = 0;
    zi = 0;
    modulus = 0;
    steps = 0;
    while (modulus < ESCAPE_Q856 && steps < orbit_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      // arithmetic shifts floor towards minus infinity
      zr = clamp_coord(((rr - ii) >>> mandel_pkg::FRAC_BITS) + cr);
      zi = clamp_coord((ri >>> (mandel_pkg::FRAC_BITS - 1)) + ci);
      modulus = $unsigned(zr * zr) + $unsigned(zi * zi);
      steps++;
    end
    r.c_re    = cr[mandel_pkg::COORD_W-1:0];
    r.c_im    = ci[mandel_pkg::COORD_W-1:0];
    r.count   = steps[mandel_pkg::COUNT_W-1:0];
    r.z_re    = zr[mandel_pkg::COORD_W-1:0];
    r.z_im    = zi[mandel_pkg::COORD_W-1:0];
    r.bounded = (modulus < ESCAPE_Q856);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_beat
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending, count %0d",
                                iteration_count));
      end else begin
        want = pending_pixels.pop_front();
        results_seen++;
        if (want.bounded) bounded_seen++;
        if (want.count > longest_orbit) longest_orbit = want.count;
        if (point_real !== want.c_re)
          flag_mismatch($sformatf("point_real %h, want %h", point_real, want.c_re));
        if (point_imag !== want.c_im)
          flag_mismatch($sformatf("point_imag %h, want %h", point_imag, want.c_im));
        if (iteration_count !== want.count)
          flag_mismatch($sformatf("iteration_count %0d, want %0d", iteration_count,
                                  want.count));
        if (final_real !== want.z_re)
          flag_mismatch($sformatf("final_real %h, want %h", final_real, want.z_re));
        if (final_imag !== want.z_im)
          flag_mismatch($sformatf("final_imag %h, want %h", final_imag, want.z_im));
        if (inside_set !== want.bounded)
          flag_mismatch($sformatf("inside_set %b, want %b", inside_set, want.bounded));
      end
    end
  end

  task automatic write_reg(logic [mandel_pkg::CFG_IDX_W-1:0] idx, longint value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[mandel_pkg::CFG_W-1:0];
    @(posedge clk);
    case (idx)
      mandel_pkg::REG_REAL_MIN:   view_re_lo  = value[mandel_pkg::CFG_W-1:0];
      mandel_pkg::REG_REAL_MAX:   view_re_hi  = value[mandel_pkg::CFG_W-1:0];
      mandel_pkg::REG_IMAG_MIN:   view_im_lo  = value[mandel_pkg::CFG_W-1:0];
      mandel_pkg::REG_IMAG_MAX:   view_im_hi  = value[mandel_pkg::CFG_W-1:0];
      mandel_pkg::REG_COLUMNS:    zone_cols   = value[mandel_pkg::DIM_W-1:0];
      mandel_pkg::REG_ROWS:       zone_rows   = value[mandel_pkg::DIM_W-1:0];
      mandel_pkg::REG_ITER_LIMIT: orbit_limit = value[mandel_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_view(longint re_lo, longint re_hi, longint im_lo, longint im_hi,
                          longint cols, longint rows, longint limit);
    views_tried++;
    write_reg(mandel_pkg::REG_REAL_MIN, re_lo);
    write_reg(mandel_pkg::REG_REAL_MAX, re_hi);
    write_reg(mandel_pkg::REG_IMAG_MIN, im_lo);
    write_reg(mandel_pkg::REG_IMAG_MAX, im_hi);
    write_reg(mandel_pkg::REG_COLUMNS, cols);
    write_reg(mandel_pkg::REG_ROWS, rows);
    write_reg(mandel_pkg::REG_ITER_LIMIT, limit);
  endtask

  task automatic send_pixel(logic [mandel_pkg::IDX_W-1:0] col, logic [mandel_pkg::IDX_W-1:0] row);
    pixel_result_t want;
    int unsigned   gap;
    bit            took;
    want = escape_time(col, row);
    gap = tight_pacing ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        = 1'b1;
    column_index = col;
    row_index    = row;
    took = 1'b0;
    // busy cannot move between the falling edge and the next rising edge
    while (!took) begin
      took = !busy;
      @(posedge clk);
      if (!took) @(negedge clk);
    end
    pending_pixels.push_back(want);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_pixels.size() != 0 || busy) @(negedge clk);
  endtask

  // a flat view maps every pixel onto the one point
  task automatic probe_point(longint re, longint im, longint limit);
    wait_idle();
    set_view(re, re, im, im, $urandom_range(0, 8191), $urandom_range(0, 8191), limit);
    send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic test_reset_state();
    // zero limit and a zero-width view straight out of reset
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(12'haaa, 12'h555);
  endtask

  task automatic test_view_extremes();
    wait_idle();
    set_view(-(64'sd1 << 30), (64'sd1 << 30) - 1, -(64'sd1 << 30), (64'sd1 << 30) - 1,
             4096, 4096, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2048, 2048);
    send_pixel(4095, 0);
    wait_idle();
    // an unused register index must leave the view alone
    write_reg(REG_UNUSED, $urandom());
    send_pixel(0, 4095);
    wait_idle();
    // reversed edges give a negative step
    set_view((64'sd1 << 30) - 1, -(64'sd1 << 30), (64'sd1 << 30) - 1, -(64'sd1 << 30),
             4096, 4096, 2);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
  endtask

  task automatic test_zone_edges();
    wait_idle();
    // zero divisor acts as one, oversized as the maximum; far pixels saturate c
    set_view(-(64'sd1 << 30), (64'sd1 << 30) - 1, (64'sd1 << 30) - 1, -(64'sd1 << 30),
             0, 8191, 3);
    send_pixel(4095, 4095);
    send_pixel(1, 0);
    send_pixel(0, 4095);
    wait_idle();
    set_view(-(64'sd1 << 29), 64'sd1 << 29, -(64'sd1 << 29), 64'sd1 << 29, 4097, 100, 4);
    send_pixel(4095, 4000);
    send_pixel(0, 99);
  endtask

  task automatic test_orbits();
    probe_point(0, 0, 65535);               // full count, never escapes
    probe_point(-Q_ONE, 0, 1000);           // orbit alternates between 0 and -1
    probe_point(-2 * Q_ONE, 0, 50);         // modulus lands exactly on four
    probe_point(Q_ONE / 4, 0, 1000);        // cusp, slow creep
    probe_point(0, Q_ONE, 200);             // pre-periodic on the imaginary axis
    probe_point(Q_ONE / 2, 0, 500);         // escapes after a few steps
  endtask

  task automatic test_random_views(int unsigned phases, int unsigned per_phase);
    longint      re_lo, re_hi, im_lo, im_hi, cols, rows, limit;
    int unsigned col, row;
    for (int unsigned p = 0; p < phases; p++) begin
      wait_idle();
      tight_pacing = (p % 3 == 2);
      case (p % 4)
        0: begin
          // anything the fields allow, short orbits
          re_lo = $urandom();
          re_hi = $urandom();
          im_lo = $urandom();
          im_hi = $urandom();
          cols  = $urandom_range(0, 8191);
          rows  = $urandom_range(0, 8191);
          limit = $urandom_range(0, 6);
        end
        3: begin
          // real part of c stays at or above two, so deep limits escape at once
          re_lo = $urandom_range(1 << 29, (1 << 30) - 1);
          re_hi = re_lo + $urandom_range(0, ((1 << 30) - 1) - re_lo);
          im_lo = $urandom();
          im_hi = $urandom();
          cols  = $urandom_range(0, 8191);
          rows  = $urandom_range(0, 8191);
          limit = $urandom_range(32768, 65535);
        end
        default: begin
          // views around the set itself
          re_lo = -longint'($urandom_range(0, 5 * Q_ONE / 2));
          re_hi = re_lo + $urandom_range(Q_ONE / 64, 3 * Q_ONE);
          im_lo = -longint'($urandom_range(0, 3 * Q_ONE / 2));
          im_hi = im_lo + $urandom_range(Q_ONE / 64, 3 * Q_ONE);
          cols  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
          rows  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
          limit = (p % 4 == 1) ? $urandom_range(1, 40) : $urandom_range(41, 150);
        end
      endcase
      set_view(re_lo, re_hi, im_lo, im_hi, cols, rows, limit);
      for (int unsigned i = 0; i < per_phase; i++) begin
        if (p % 4 == 0 || cols > 4096 || cols == 0 || $urandom_range(0, 9) == 0) begin
          col = $urandom_range(0, 4095);
        end else begin
          col = $urandom_range(0, cols - 1);
        end
        if (p % 4 == 0 || rows > 4096 || rows == 0 || $urandom_range(0, 9) == 0) begin
          row = $urandom_range(0, 4095);
        end else begin
          row = $urandom_range(0, rows - 1);
        end
        send_pixel(col, row);
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
    end
    tight_pacing = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    start        = 1'b0;
    column_index = '0;
    row_index    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_view_extremes();
    test_zone_edges();
    test_orbits();
    test_random_views(8, 75);

    wait_idle();
    repeat (20) @(negedge clk);
    $display("run covered %0d pixels under %0d view settings in %0d cycles",
             results_seen, views_tried, cycle_count);
    $display("%0d points stayed bounded, longest orbit %0d iterations",
             bounded_seen, longest_orbit);
    if (mismatches == 0) begin
      $display("tb_mandelbrot_escape_time_pixel: clean");
    end else begin
      $display("tb_mandelbrot_escape_time_pixel: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mandel_pkg.sv
src/mandel_mul.sv
src/mandel_div.sv
src/mandelbrot_escape_time_pixel.sv
sim/tb_mandelbrot_escape_time_pixel.sv
